// File: design/lcp_interval_traversal_top_defines.svh
// ----------------------------------------------------------------------------
// lcp_interval_traversal_top_defines.svh
// Assertion macros used by the interval traversal top module.
// ----------------------------------------------------------------------------
`ifndef LCP_INTERVAL_TRAVERSAL_TOP_DEFINES_SVH
`define LCP_INTERVAL_TRAVERSAL_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check that prop holds at every clock edge out of reset.
`define LCP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that cons holds in the cycle after ante.
`define LCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LCP_ASSERT(label, clk, rst_n, prop, msg)
`define LCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: design/lcp_it_pkg.sv
// ----------------------------------------------------------------------------
// lcp_it_pkg
// Types and constants of the lcp-interval traversal block.
// ----------------------------------------------------------------------------
`default_nettype none

package lcp_it_pkg;

    localparam int LCP_W    = 21;
    localparam int SFX_W    = 20;
    localparam int STAGE_W  = 21;
    localparam int LEN_W    = 21;
    localparam int BOUND_W  = 22;
    localparam int RIGHT_W  = 21;
    localparam int HEIGHT_W = 22;
    localparam int KIND_W   = 3;
    localparam int CFG_W    = 21;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 72;

    // Event kinds
    localparam logic [KIND_W-1:0] KIND_BEGIN  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POP    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BRANCH = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LEAF   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_END    = 3'd4;

    // Configuration register indexes
    localparam logic CFG_FIRST_STAGE  = 1'b0;
    localparam logic CFG_TOTAL_LENGTH = 1'b1;

    typedef struct packed {
        logic signed [BOUND_W-1:0]  left;
        logic signed [HEIGHT_W-1:0] height;
    } stack_entry_t;

    localparam logic signed [BOUND_W-1:0]  MINUS_ONE_B = '1;
    localparam logic signed [HEIGHT_W-1:0] MINUS_ONE_H = '1;

endpackage

`default_nettype wire

// File: design/lcp_it_ram.sv
// ----------------------------------------------------------------------------
// lcp_it_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module lcp_it_ram #(
    parameter int WIDTH = 44,
    parameter int DEPTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: design/lcp_interval_traversal_top.sv
// ----------------------------------------------------------------------------
// lcp_interval_traversal_top
// Bottom-up walk of the lcp-interval tree of a suffix array.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry one suffix-array stage each: the lcp value and the
//   suffix start in s_tdata, s_tlast marking the closing beat of a traversal.
//   Each input beat yields a run of event beats on the master side: begin
//   (first beat of a traversal), one pop per stacked interval deeper than the
//   lcp value, an optional branch push, then a leaf push or, on the closing
//   beat, an end event. m_tlast marks the last event of each input beat.
//   Items are taken one at a time: the next input beat is accepted only once
//   the current item has issued its leaf or end event. Each pop reads the new
//   stack top from the stack RAM, whose read data is registered.
//   The first event of an item is set in the output register by the BEGIN
//   state, else by CMP, or by TAIL when the item emits only its leaf or end.
//   The output register decouples the sides: the next input beat is accepted
//   while the last event of the previous one still waits. A stalled receiver
//   holds the walk at the next event to be emitted.
//   Reset empties the stack down to its sentinel, clears the open-traversal
//   flag and sets first_stage and total_length to 1. Write configuration only
//   while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lcp_interval_traversal_top_defines.svh"

module lcp_interval_traversal_top #(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [20:0] cfg_data,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // [20:0] lcp_value, [40:21] suffix_start
    input  wire logic        s_tlast,   // is_final
    // event stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // [21:0] left_bound, [42:22] right_bound,
                                        // [64:43] height, [65] overflow
    output logic [2:0]       m_tuser,   // kind
    output logic             m_tlast    // last
);

    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int AW  = $clog2(STACK_DEPTH);

    localparam int BW = lcp_it_pkg::BOUND_W;
    localparam int HW = lcp_it_pkg::HEIGHT_W;
    localparam int SW = lcp_it_pkg::STAGE_W;

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;   // wait for an input beat
    localparam logic [2:0] ST_BEGIN = 3'd1;   // emit the begin event
    localparam logic [2:0] ST_CMP   = 3'd2;   // pop, or branch push
    localparam logic [2:0] ST_LOAD  = 3'd3;   // refill the top cache from RAM
    localparam logic [2:0] ST_TAIL  = 3'd4;   // leaf push or end event

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [2:0]            state_reg, state_next;
    logic [SPW-1:0]        sp_reg, sp_next;
    logic signed [BW-1:0]  top_left_reg, top_left_next;
    logic signed [HW-1:0]  top_height_reg, top_height_next;
    logic                  begun_reg, begun_next;
    logic [SW-1:0]         stage_reg, stage_next;
    logic [20:0]           first_stage_reg;
    logic [lcp_it_pkg::LEN_W-1:0] total_length_reg;

    // current item
    logic signed [HW-1:0]  lcp_reg, lcp_next;
    logic [lcp_it_pkg::SFX_W-1:0] sfx_reg, sfx_next;
    logic                  fin_reg, fin_next;
    logic [SW-1:0]         k_reg, k_next;
    logic signed [BW-1:0]  lca_left_reg, lca_left_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [2:0]            out_kind_reg, out_kind_next;
    logic signed [BW-1:0]  out_left_reg, out_left_next;
    logic [lcp_it_pkg::RIGHT_W-1:0] out_right_reg, out_right_next;
    logic signed [HW-1:0]  out_height_reg, out_height_next;
    logic                  out_ovf_reg, out_ovf_next;
    logic                  out_last_reg, out_last_next;

    // stack RAM ports
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    lcp_it_pkg::stack_entry_t ram_wdata;
    logic [AW-1:0]            ram_raddr;
    lcp_it_pkg::stack_entry_t ram_rdata;

    // ------------------------------------------------------------------
    // Stack storage. Entry i (1..STACK_DEPTH) lives at address i-1; the
    // current top is also cached in registers, so a push never needs a
    // read and a pop only needs the entry below it.
    // ------------------------------------------------------------------
    lcp_it_ram #(
        .WIDTH ($bits(lcp_it_pkg::stack_entry_t)),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic                 adv;
    logic                 stack_full;
    logic                 do_pop;
    logic                 do_branch;
    logic [SW-1:0]        k_in;
    logic [SW-1:0]        k_minus_one;
    logic signed [HW-1:0] leaf_height;

    assign adv         = !out_valid_reg || m_tready;
    assign stack_full  = (sp_reg == SPW'(STACK_DEPTH));
    assign do_pop      = (sp_reg != '0) && (top_height_reg > lcp_reg);
    assign do_branch   = (top_height_reg < lcp_reg);
    assign k_in        = begun_reg ? stage_reg : first_stage_reg;
    assign k_minus_one = k_reg - SW'(1);
    assign leaf_height = $signed({1'b0, total_length_reg})
                       - $signed({2'b00, sfx_reg});

    always_comb
    begin
        state_next      = state_reg;
        sp_next         = sp_reg;
        top_left_next   = top_left_reg;
        top_height_next = top_height_reg;
        begun_next      = begun_reg;
        stage_next      = stage_reg;
        lcp_next        = lcp_reg;
        sfx_next        = sfx_reg;
        fin_next        = fin_reg;
        k_next          = k_reg;
        lca_left_next   = lca_left_reg;

        out_valid_next  = out_valid_reg && !m_tready;
        out_kind_next   = out_kind_reg;
        out_left_next   = out_left_reg;
        out_right_next  = out_right_reg;
        out_height_next = out_height_reg;
        out_ovf_next    = out_ovf_reg;
        out_last_next   = out_last_reg;

        ram_we          = 1'b0;
        ram_waddr       = sp_reg[AW-1:0];
        ram_wdata       = '{left: top_left_reg, height: top_height_reg};
        // entry below the top, at address sp-2
        ram_raddr       = AW'(sp_reg - SPW'(2));

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    lcp_next      = s_tlast ? lcp_it_pkg::MINUS_ONE_H
                                            : $signed({1'b0, s_tdata[20:0]});
                    sfx_next      = s_tdata[40:21];
                    fin_next      = s_tlast;
                    k_next        = k_in;
                    lca_left_next = $signed({1'b0, k_in}) - $signed(BW'(1));
                    state_next    = begun_reg ? ST_CMP : ST_BEGIN;
                end
            end

            ST_BEGIN:
            begin
                if (adv)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = lcp_it_pkg::KIND_BEGIN;
                    out_left_next   = lcp_it_pkg::MINUS_ONE_B;
                    out_right_next  = '0;
                    out_height_next = lcp_it_pkg::MINUS_ONE_H;
                    out_ovf_next    = 1'b0;
                    out_last_next   = 1'b0;
                    begun_next      = 1'b1;
                    state_next      = ST_CMP;
                end
            end

            ST_CMP:
            begin
                if (adv)
                begin
                    if (do_pop)
                    begin
                        out_valid_next  = 1'b1;
                        out_kind_next   = lcp_it_pkg::KIND_POP;
                        out_left_next   = top_left_reg;
                        out_right_next  = k_minus_one;
                        out_height_next = top_height_reg;
                        out_ovf_next    = 1'b0;
                        out_last_next   = 1'b0;
                        lca_left_next   = top_left_reg;
                        sp_next         = sp_reg - SPW'(1);
                        state_next      = ST_LOAD;
                    end
                    else if (do_branch)
                    begin
                        out_valid_next  = 1'b1;
                        out_kind_next   = lcp_it_pkg::KIND_BRANCH;
                        out_left_next   = lca_left_reg;
                        out_right_next  = '0;
                        out_height_next = lcp_reg;
                        out_ovf_next    = stack_full;
                        out_last_next   = 1'b0;
                        if (!stack_full)
                        begin
                            ram_we          = 1'b1;
                            ram_wdata       = '{left: lca_left_reg, height: lcp_reg};
                            top_left_next   = lca_left_reg;
                            top_height_next = lcp_reg;
                            sp_next         = sp_reg + SPW'(1);
                        end
                        state_next = ST_TAIL;
                    end
                    else
                    begin
                        state_next = ST_TAIL;
                    end
                end
            end

            ST_LOAD:
            begin
                if (sp_reg == '0)
                begin
                    top_left_next   = lcp_it_pkg::MINUS_ONE_B;
                    top_height_next = lcp_it_pkg::MINUS_ONE_H;
                end
                else
                begin
                    top_left_next   = ram_rdata.left;
                    top_height_next = ram_rdata.height;
                end
                state_next = ST_CMP;
            end

            ST_TAIL:
            begin
                if (adv)
                begin
                    out_valid_next = 1'b1;
                    out_right_next = '0;
                    out_last_next  = 1'b1;
                    if (fin_reg)
                    begin
                        out_kind_next   = lcp_it_pkg::KIND_END;
                        out_left_next   = '0;
                        out_height_next = '0;
                        out_ovf_next    = 1'b0;
                        sp_next         = '0;
                        top_left_next   = lcp_it_pkg::MINUS_ONE_B;
                        top_height_next = lcp_it_pkg::MINUS_ONE_H;
                        begun_next      = 1'b0;
                        stage_next      = first_stage_reg;
                    end
                    else
                    begin
                        out_kind_next   = lcp_it_pkg::KIND_LEAF;
                        out_left_next   = $signed({1'b0, k_reg});
                        out_height_next = leaf_height;
                        out_ovf_next    = stack_full;
                        if (!stack_full)
                        begin
                            ram_we          = 1'b1;
                            ram_wdata       = '{left: $signed({1'b0, k_reg}),
                                                height: leaf_height};
                            top_left_next   = $signed({1'b0, k_reg});
                            top_height_next = leaf_height;
                            sp_next         = sp_reg + SPW'(1);
                        end
                        stage_next = k_reg + SW'(1);
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            sp_reg           <= '0;
            top_left_reg     <= lcp_it_pkg::MINUS_ONE_B;
            top_height_reg   <= lcp_it_pkg::MINUS_ONE_H;
            begun_reg        <= 1'b0;
            stage_reg        <= SW'(1);
            first_stage_reg  <= 21'd1;
            total_length_reg <= 21'd1;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sp_reg         <= sp_next;
            top_left_reg   <= top_left_next;
            top_height_reg <= top_height_next;
            begun_reg      <= begun_next;
            stage_reg      <= stage_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    lcp_it_pkg::CFG_FIRST_STAGE:  first_stage_reg  <= cfg_data;
                    lcp_it_pkg::CFG_TOTAL_LENGTH: total_length_reg <= cfg_data;
                    default:                      ;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        lcp_reg        <= lcp_next;
        sfx_reg        <= sfx_next;
        fin_reg        <= fin_next;
        k_reg          <= k_next;
        lca_left_reg   <= lca_left_next;
        out_kind_reg   <= out_kind_next;
        out_left_reg   <= out_left_next;
        out_right_reg  <= out_right_next;
        out_height_reg <= out_height_next;
        out_ovf_reg    <= out_ovf_next;
        out_last_reg   <= out_last_next;
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b000000, out_ovf_reg, out_height_reg, out_right_reg, out_left_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `LCP_ASSERT(a_sp_bound, clk, rst_n, sp_reg <= SPW'(STACK_DEPTH), "stack pointer past depth")
    `LCP_ASSERT(a_sentinel, clk, rst_n,
        (sp_reg != '0) || (state_reg == ST_LOAD) || (top_height_reg == lcp_it_pkg::MINUS_ONE_H),
        "top cache lost the sentinel")
    `LCP_ASSERT_NEXT(a_pop_step, clk, rst_n, (state_reg == ST_CMP) && adv && do_pop,
        (sp_reg == $past(sp_reg) - SPW'(1)) && (state_reg == ST_LOAD),
        "pop did not step the stack down")
    `LCP_ASSERT_NEXT(a_end_clears, clk, rst_n, (state_reg == ST_TAIL) && adv && fin_reg,
        (sp_reg == '0) && !begun_reg && m_tlast && (m_tuser == lcp_it_pkg::KIND_END),
        "end event left traversal state behind")

endmodule

`default_nettype wire
